// ===== rtl/mnes_pkg.sv =====
// package for the midi note event serializer
// holds the command record, queue sizing, status codes and the byte sequencer states
`default_nettype none

package mnes_pkg;

	localparam int DELAY_W = 14;
	localparam int PITCH_W = 7;
	localparam int CHAN_W  = 4;
	localparam int VEL_W   = 7;
	localparam int BYTE_W  = 8;

	localparam logic [DELAY_W-1:0] DELAY_MAX = 14'h3fff;

	// high nibbles of the status bytes, channel goes in the low nibble
	localparam logic [3:0] NOTE_ON_HI  = 4'h9;
	localparam logic [3:0] NOTE_OFF_HI = 4'h8;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [DELAY_W-1:0] delay;
		logic [DELAY_W-1:0] length;
		logic [CHAN_W-1:0]  channel;
		logic [PITCH_W-1:0] pitch;
		logic [VEL_W-1:0]   velocity;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_DLY_HI,
		ST_DLY_LO,
		ST_ON,
		ST_ON_PITCH,
		ST_ON_VEL,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_OFF,
		ST_OFF_PITCH,
		ST_OFF_VEL
	} seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/mnes_if.sv =====
// channel interfaces: note items in, midi bytes out
// depends on mnes_pkg for field widths
`default_nettype none

interface mnes_note_if;
	import mnes_pkg::*;

	logic               valid;
	logic               ready;
	logic               is_rest;
	logic [PITCH_W-1:0] pitch;
	logic [CHAN_W-1:0]  channel;
	logic [VEL_W-1:0]   velocity;
	logic [DELAY_W-1:0] length;

	modport source (output valid, is_rest, pitch, channel, velocity, length, input ready);
	modport sink (input valid, is_rest, pitch, channel, velocity, length, output ready);
endinterface

interface mnes_byte_if;
	import mnes_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	modport source (output valid, out_byte, last, input ready);
	modport sink (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/midi_note_event_serializer_top.sv =====
// top level of the midi note event serializer: front end, command queue, back end
// depends on mnes_pkg, mnes_if, mnes_front, mnes_queue, mnes_back
//
// channel  dir  handshake      payload
// note     in   valid/ready    is_rest, pitch, channel, velocity, length
// midi     out  valid/ready    out_byte, last
//
// one output byte per cycle while the sink is ready and a command is in hand; 8 to 10 bytes per note
// a rest only adds its length to the pending delay and emits nothing
// the byte sequencer in the back end sets the rate; a two-entry queue lets
// the front keep taking items while bytes drain
// arst_n clears pending delay, queue and output valid; no clearing pass

`default_nettype none

module midi_note_event_serializer_top
	import mnes_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	mnes_note_if.sink   note,
	mnes_byte_if.source midi
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_valid;
	cmd_t q_wr;
	cmd_t q_rd;

	mnes_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.note   (note),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wr)
	);

	mnes_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_data   (q_wr),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rd_data   (q_rd)
	);

	mnes_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_rd),
		.q_pop   (q_pop),
		.midi    (midi)
	);

endmodule

`default_nettype wire

// ===== rtl/mnes_front.sv =====
// front end: accepts note items, keeps the pending delay, queues note commands
// depends on mnes_pkg and mnes_note_if
`default_nettype none

module mnes_front
	import mnes_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	mnes_note_if.sink    note,
	input  wire logic    q_full,
	output logic         q_push,
	output cmd_t         q_data
);

	logic [DELAY_W-1:0] pending_delay_q;
	logic [DELAY_W:0]   sum;
	logic               accept;

	assign note.ready = !q_full;
	assign accept     = note.valid && note.ready;
	assign q_push     = accept && !note.is_rest;
	assign sum        = {1'b0, pending_delay_q} + {1'b0, note.length};

	always_comb begin
		q_data.delay    = pending_delay_q;
		q_data.length   = note.length;
		q_data.channel  = note.channel;
		q_data.pitch    = note.pitch;
		q_data.velocity = note.velocity;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_delay_q <= '0;
		end else if (accept) begin
			if (note.is_rest) begin
				// saturating add of the rest length
				pending_delay_q <= sum[DELAY_W] ? DELAY_MAX : sum[DELAY_W-1:0];
			end else begin
				pending_delay_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mnes_queue.sv =====
// short command queue between front and back end
// depends on mnes_pkg
`default_nettype none

module mnes_queue
	import mnes_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  wr_data,
	output logic       full,
	input  wire logic  pop,
	output logic       not_empty,
	output cmd_t       rd_data
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mnes_back.sv =====
// back end: walks one note command byte by byte into a registered output
// depends on mnes_pkg and mnes_byte_if
`default_nettype none

module mnes_back
	import mnes_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire cmd_t  q_data,
	output logic       q_pop,
	mnes_byte_if.source midi
);

	seq_state_t        state_q;
	seq_state_t        state_d;
	cmd_t              cmd_q;
	logic              busy_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;
	logic              adv;
	logic              fin;
	logic [BYTE_W-1:0] byte_d;
	seq_state_t        start_state;

	assign midi.valid    = out_valid_q;
	assign midi.out_byte = out_byte_q;
	assign midi.last     = last_q;

	// output slot free or being drained this cycle
	assign adv   = busy_q && (!out_valid_q || midi.ready);
	assign fin   = adv && (state_q == ST_OFF_VEL);
	assign q_pop = q_valid && (!busy_q || fin);

	// a delay below 128 needs only the low byte
	assign start_state = (q_data.delay[DELAY_W-1:7] == '0) ? ST_DLY_LO : ST_DLY_HI;

	always_comb begin
		state_d = state_q;
		byte_d  = '0;
		unique case (state_q)
			ST_DLY_HI: begin
				byte_d  = {1'b1, cmd_q.delay[DELAY_W-1:7]};
				state_d = ST_DLY_LO;
			end
			ST_DLY_LO: begin
				byte_d  = {1'b0, cmd_q.delay[6:0]};
				state_d = ST_ON;
			end
			ST_ON: begin
				byte_d  = {NOTE_ON_HI, cmd_q.channel};
				state_d = ST_ON_PITCH;
			end
			ST_ON_PITCH: begin
				byte_d  = {1'b0, cmd_q.pitch};
				state_d = ST_ON_VEL;
			end
			ST_ON_VEL: begin
				byte_d  = {1'b0, cmd_q.velocity};
				state_d = (cmd_q.length[DELAY_W-1:7] == '0) ? ST_LEN_LO : ST_LEN_HI;
			end
			ST_LEN_HI: begin
				byte_d  = {1'b1, cmd_q.length[DELAY_W-1:7]};
				state_d = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				byte_d  = {1'b0, cmd_q.length[6:0]};
				state_d = ST_OFF;
			end
			ST_OFF: begin
				byte_d  = {NOTE_OFF_HI, cmd_q.channel};
				state_d = ST_OFF_PITCH;
			end
			ST_OFF_PITCH: begin
				byte_d  = {1'b0, cmd_q.pitch};
				state_d = ST_OFF_VEL;
			end
			ST_OFF_VEL: begin
				byte_d  = {1'b0, cmd_q.velocity};
				state_d = ST_DLY_LO;
			end
			default: begin
				byte_d  = '0;
				state_d = ST_DLY_LO;
			end
		endcase
		if (q_pop) begin
			state_d = start_state;
		end else if (!adv) begin
			state_d = state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DLY_LO;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (adv) begin
			out_byte_q <= byte_d;
			last_q     <= (state_q == ST_OFF_VEL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (midi.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	// the closing byte is a velocity, never a status byte
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> out_byte_q[BYTE_W-1] == 1'b0)
		else $error("last flag on a status byte");

	// note-on status is loaded when the sequencer passes its state
	a_note_on: assert property (@(posedge clk) disable iff (!arst_n)
		adv && state_q == ST_ON |=> out_valid_q && out_byte_q[BYTE_W-1:4] == NOTE_ON_HI)
		else $error("note-on status byte not emitted");

	// a new command is only taken when the previous one is done
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && busy_q |-> state_q == ST_OFF_VEL && adv)
		else $error("command taken while one is in flight");
`endif

endmodule

`default_nettype wire

// ===== bench/mnes_event_checker.sv =====
`timescale 1ns / 100ps
// bench-side byte predictor and scoreboard for the midi note event serializer
// watches the note and midi channels; depends on mnes_pkg and mnes_if
module mnes_event_checker
	import mnes_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	mnes_note_if      note,
	mnes_byte_if      midi,
	output int        errors,
	output int        outstanding
);

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              last;
	} midi_byte_t;

	midi_byte_t         midi_expect[$];
	logic [DELAY_W-1:0] delay_owed;

	initial begin
		errors = 0;
		outstanding = 0;
	end

	function automatic void push_byte(input logic [BYTE_W-1:0] value, input logic last);
		midi_byte_t b;
		b.value = value;
		b.last = last;
		midi_expect.insert(midi_expect.size(), b);
	endfunction

	// short delays take one byte, longer ones the two-byte vlq
	function automatic void push_delay(input logic [DELAY_W-1:0] d);
		if (d < 128) begin
			push_byte({1'b0, d[6:0]}, 1'b0);
		end else begin
			push_byte({1'b1, d[13:7]}, 1'b0);
			push_byte({1'b0, d[6:0]}, 1'b0);
		end
	endfunction

	function automatic void encode_note(
		input logic               is_rest,
		input logic [PITCH_W-1:0] pitch,
		input logic [CHAN_W-1:0]  channel,
		input logic [VEL_W-1:0]   velocity,
		input logic [DELAY_W-1:0] length
	);
		logic [DELAY_W:0] sum;
		if (is_rest) begin
			sum = {1'b0, delay_owed} + {1'b0, length};
			delay_owed = (sum > {1'b0, DELAY_MAX}) ? DELAY_MAX : sum[DELAY_W-1:0];
		end else begin
			push_delay(delay_owed);
			delay_owed = '0;
			push_byte({NOTE_ON_HI, channel}, 1'b0);
			push_byte({1'b0, pitch}, 1'b0);
			push_byte({1'b0, velocity}, 1'b0);
			push_delay(length);
			push_byte({NOTE_OFF_HI, channel}, 1'b0);
			push_byte({1'b0, pitch}, 1'b0);
			push_byte({1'b0, velocity}, 1'b1);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		midi_byte_t want;
		if (!arst_n) begin
			delay_owed = '0;
			midi_expect.delete();
		end else begin
			if (note.valid && note.ready)
				encode_note(note.is_rest, note.pitch, note.channel, note.velocity, note.length);
			if (midi.valid && midi.ready) begin
				if (midi_expect.size() == 0) begin
					$error("unexpected midi byte %h (last %b)", midi.out_byte, midi.last);
					errors = errors + 1;
				end else begin
					want = midi_expect.pop_front();
					if (midi.out_byte !== want.value) begin
						$error("out_byte: expected %h, actual %h", want.value, midi.out_byte);
						errors = errors + 1;
					end
					if (midi.last !== want.last) begin
						$error("last: expected %b, actual %b", want.last, midi.last);
						errors = errors + 1;
					end
				end
			end
		end
		outstanding = midi_expect.size();
	end

endmodule

// ===== bench/midi_note_event_serializer_top_test.sv =====
`timescale 1ns / 100ps
// bench top for the midi note event serializer: clock, reset, note stimulus,
// midi sink stalls and verdict; depends on mnes_pkg, mnes_if and mnes_event_checker
module midi_note_event_serializer_top_test;
	import mnes_pkg::*;

	typedef struct {
		logic               is_rest;
		logic [PITCH_W-1:0] pitch;
		logic [CHAN_W-1:0]  channel;
		logic [VEL_W-1:0]   velocity;
		logic [DELAY_W-1:0] length;
	} note_item_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   burst_left;
	bit   quiet;

	mnes_note_if note_ch();
	mnes_byte_if midi_ch();

	midi_note_event_serializer_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.note   (note_ch),
		.midi   (midi_ch)
	);

	mnes_event_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.note        (note_ch),
		.midi        (midi_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic note_item_t make_item(input logic is_rest, input int pitch,
			input int channel, input int velocity, input int length);
		note_item_t n;
		n.is_rest = is_rest;
		n.pitch = PITCH_W'(pitch);
		n.channel = CHAN_W'(channel);
		n.velocity = VEL_W'(velocity);
		n.length = DELAY_W'(length);
		return n;
	endfunction

	// weighted toward the one/two byte boundary and the saturation end
	function automatic int pick_length(input logic is_rest);
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 127);
			1: return $urandom_range(126, 129);
			2: return 16383 - $urandom_range(0, 3);
			3: return is_rest ? $urandom_range(0, 300) : $urandom_range(0, 16383);
			default: return $urandom_range(0, 16383);
		endcase
	endfunction

	task automatic send_note(input note_item_t n);
		int gap;
		@(negedge clk);
		note_ch.valid <= 1'b1;
		note_ch.is_rest <= n.is_rest;
		note_ch.pitch <= n.pitch;
		note_ch.channel <= n.channel;
		note_ch.velocity <= n.velocity;
		note_ch.length <= n.length;
		do @(posedge clk); while (!note_ch.ready);
		burst_left = burst_left - 1;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = quiet ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				note_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// hold off until every byte in flight has drained
	task automatic drain();
		@(negedge clk);
		note_ch.valid <= 1'b0;
		wait (outstanding == 0);
	endtask

	// midi sink: stall pattern switches mode every so often
	initial begin
		int mode;
		int span;
		midi_ch.ready = 1'b0;
		mode = 0;
		span = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 200);
			end
			span = span - 1;
			case (mode)
				0: midi_ch.ready <= 1'b1;
				1: midi_ch.ready <= ($urandom_range(0, 3) != 0);
				2: midi_ch.ready <= ($urandom_range(0, 3) == 0);
				default: midi_ch.ready <= ($urandom_range(0, 11) == 0);
			endcase
		end
	end

	initial begin
		logic rest;
		note_ch.valid = 1'b0;
		note_ch.is_rest = 1'b0;
		note_ch.pitch = '0;
		note_ch.channel = '0;
		note_ch.velocity = '0;
		note_ch.length = '0;
		burst_left = 1;
		quiet = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// zero pending delay goes out as a single zero byte
		send_note(make_item(1'b0, 0, 0, 0, 0));
		send_note(make_item(1'b0, 127, 15, 127, 127));
		send_note(make_item(1'b0, 60, 5, 100, 128));
		send_note(make_item(1'b0, 64, 10, 1, 16383));
		send_note(make_item(1'b1, 85, 3, 42, 127));
		send_note(make_item(1'b0, 1, 1, 64, 1));
		// two rests summing to the first two-byte delay
		send_note(make_item(1'b1, 0, 0, 0, 100));
		send_note(make_item(1'b1, 127, 15, 127, 28));
		send_note(make_item(1'b0, 42, 9, 85, 255));
		// saturation of the pending delay
		send_note(make_item(1'b1, 10, 2, 20, 16383));
		send_note(make_item(1'b1, 11, 2, 21, 16383));
		send_note(make_item(1'b0, 72, 7, 90, 200));
		send_note(make_item(1'b1, 5, 4, 6, 0));
		send_note(make_item(1'b0, 50, 12, 33, 256));
		send_note(make_item(1'b1, 1, 1, 1, 8000));
		send_note(make_item(1'b1, 2, 2, 2, 8383));
		send_note(make_item(1'b1, 3, 3, 3, 1));
		send_note(make_item(1'b0, 99, 14, 120, 129));
		send_note(make_item(1'b0, 33, 8, 0, 16256));
		drain();

		for (int i = 0; i < 270; i++) begin
			if (i % 60 == 59) begin
				drain();
				quiet = ($urandom_range(0, 2) == 0);
			end
			rest = ($urandom_range(0, 3) == 0);
			send_note(make_item(rest, $urandom_range(0, 127), $urandom_range(0, 15),
				$urandom_range(0, 127), pick_length(rest)));
		end

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mnes_pkg.sv
rtl/mnes_if.sv
rtl/mnes_front.sv
rtl/mnes_queue.sv
rtl/mnes_back.sv
rtl/midi_note_event_serializer_top.sv
bench/mnes_event_checker.sv
bench/midi_note_event_serializer_top_test.sv
